### rtl/sfpa_pkg.sv
// ----------------------------------------------------------------------------
// sfpa_pkg
// Shared types and constants for the saturating fixed-point ALU.
// ----------------------------------------------------------------------------
package sfpa_pkg;

	localparam int FRAC_BITS_DEF = 8;

	localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

	typedef enum logic [3:0] {
		FN_ADD = 4'd0,
		FN_SUB = 4'd1,
		FN_MUL = 4'd2,
		FN_DIV = 4'd3,
		FN_INC = 4'd4,
		FN_DEC = 4'd5,
		FN_ITF = 4'd6,
		FN_FTI = 4'd7,
		FN_CLR = 4'd8
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [3:0]         func;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} in_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic               overflow;
		logic               sticky_overflow;
		logic               less;
		logic               equal;
		logic               greater;
	} out_t;

endpackage

### rtl/sfpa_div.sv
// ----------------------------------------------------------------------------
// sfpa_div
// Radix-2 restoring divider on unsigned magnitudes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sfpa_div #(
	parameter int FRAC_BITS = sfpa_pkg::FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [32+FRAC_BITS-1:0] dividend,
	input  logic [31:0]             divisor,
	output logic                    done,
	output logic [32+FRAC_BITS-1:0] quo,
	output logic [31:0]             rem
);

	localparam int QW = 32 + FRAC_BITS;
	localparam int CW = $clog2(QW + 1);

	logic [31:0]   rem_q;
	logic [QW-1:0] quo_q;
	logic [31:0]   dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [32:0] trial;
	logic [33:0] diff;
	logic        fits;

	always_comb begin
		trial = {rem_q, quo_q[QW-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
		fits  = !diff[33];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// shift the next dividend bit in, subtract if the divisor fits
			rem_q <= fits ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

### rtl/saturating_fixed_point_alu_core.sv
// ----------------------------------------------------------------------------
// saturating_fixed_point_alu_core
// Signed 32-bit saturating fixed-point ALU with an iterative divider.
// ----------------------------------------------------------------------------
// Items arrive on in_valid/in_stall/in_data (opcode and two raw operands) and
// each gives exactly one result on out_valid/out_stall/out_data. A transfer
// happens on a rising edge with valid high and stall low.
// One item is worked on at a time; in_stall stays high from the transfer
// until the result has been written to the output register.
// Add, subtract, increment, decrement, conversions, clear and unused codes:
// the result is computed in the execute state and loaded into the output
// register from the finish state. Multiply: one 32x32 product in the
// execute state, then rounding and saturation in the multiply state.
// Divide: the radix-2 divider producing 32 + FRAC_BITS quotient bits, one
// a cycle, runs in the divide state. Divide by zero skips the divider.
// The output register lets the next item be taken while a result waits; a
// finished result is held internally until out_stall drops.
// Reset clears the sequencer, the output valid and the sticky overflow flag.
// ----------------------------------------------------------------------------
module saturating_fixed_point_alu_core #(
	parameter int FRAC_BITS = sfpa_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  sfpa_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output sfpa_pkg::out_t  out_data
);

	localparam int QW = 32 + FRAC_BITS;

	sfpa_pkg::state_t state_q, state_d;

	logic [3:0]         func_q;
	logic signed [31:0] a_q, b_q;
	logic signed [31:0] res_q;
	logic               ovf_q;
	logic [63:0]        prod_q;
	sfpa_pkg::out_t     out_q;
	logic               out_valid_q;
	logic               sticky_q;

	logic [31:0] ma, mb;
	logic        neg;
	logic        b_zero;

	logic signed [32:0] add_x, add_y, add_s;
	logic               add_ovf;
	logic signed [31:0] add_res;

	logic [FRAC_BITS:0] itf_top;
	logic               itf_ovf;
	logic signed [31:0] itf_res;
	logic [31:0]        fti_mag;
	logic signed [31:0] fti_res;

	logic [63:0] mul_rnd, mul_mag;
	logic        div_up;
	logic [63:0] div_mag;

	logic          div_start;
	logic          div_done;
	logic [QW-1:0] div_quo;
	logic [31:0]   div_rem;

	logic out_free;
	logic out_load;
	logic sticky_d;

	// returns {overflow, value} for a magnitude and a sign
	function automatic logic [32:0] sat_mag(input logic [63:0] m, input logic ng);
		logic        ov;
		logic [31:0] r;
		if (ng) begin
			ov = (|m[63:32]) || (m[31] && (|m[30:0]));
			r  = ov ? sfpa_pkg::INT_MIN : (32'd0 - m[31:0]);
		end else begin
			ov = |m[63:31];
			r  = ov ? sfpa_pkg::INT_MAX : m[31:0];
		end
		return {ov, r};
	endfunction

	// operand magnitudes and shared adder
	always_comb begin
		ma     = a_q[31] ? (32'd0 - a_q) : a_q;
		mb     = b_q[31] ? (32'd0 - b_q) : b_q;
		neg    = a_q[31] ^ b_q[31];
		b_zero = (b_q == 32'sd0);

		add_x = {a_q[31], a_q};
		case (func_q)
			sfpa_pkg::FN_SUB: add_y = -{b_q[31], b_q};
			sfpa_pkg::FN_INC: add_y = 33'sd1;
			sfpa_pkg::FN_DEC: add_y = -33'sd1;
			default:          add_y = {b_q[31], b_q};
		endcase
		add_s   = add_x + add_y;
		add_ovf = add_s[32] ^ add_s[31];
		add_res = add_ovf ? (add_s[32] ? sfpa_pkg::INT_MIN : sfpa_pkg::INT_MAX) : add_s[31:0];

		itf_top = a_q[31 -: FRAC_BITS+1];
		itf_ovf = !((&itf_top) || !(|itf_top));
		itf_res = itf_ovf ? (a_q[31] ? sfpa_pkg::INT_MIN : sfpa_pkg::INT_MAX)
		                  : (a_q <<< FRAC_BITS);

		fti_mag = ma >> FRAC_BITS;
		fti_res = a_q[31] ? (32'd0 - fti_mag) : fti_mag;

		mul_rnd = prod_q + (64'd1 << (FRAC_BITS - 1));
		mul_mag = mul_rnd >> FRAC_BITS;

		// round half away from zero: bump when twice the remainder reaches the divisor
		div_up  = ({div_rem, 1'b0} >= {1'b0, mb});
		div_mag = 64'(div_quo) + 64'(div_up);
	end

	sfpa_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({ma, {FRAC_BITS{1'b0}}}),
		.divisor  (mb),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sfpa_pkg::ST_IDLE: begin
				if (in_valid) state_d = sfpa_pkg::ST_EXEC;
			end
			sfpa_pkg::ST_EXEC: begin
				if (func_q == sfpa_pkg::FN_MUL) state_d = sfpa_pkg::ST_MUL;
				else if (func_q == sfpa_pkg::FN_DIV && !b_zero) state_d = sfpa_pkg::ST_DIV;
				else state_d = sfpa_pkg::ST_FIN;
			end
			sfpa_pkg::ST_MUL: state_d = sfpa_pkg::ST_FIN;
			sfpa_pkg::ST_DIV: begin
				if (div_done) state_d = sfpa_pkg::ST_FIN;
			end
			sfpa_pkg::ST_FIN: begin
				if (out_free) state_d = sfpa_pkg::ST_IDLE;
			end
			default: state_d = sfpa_pkg::ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_stall  = (state_q != sfpa_pkg::ST_IDLE);
		div_start = (state_q == sfpa_pkg::ST_EXEC) && (func_q == sfpa_pkg::FN_DIV) && !b_zero;
		out_free  = !out_valid_q || !out_stall;
		out_load  = (state_q == sfpa_pkg::ST_FIN) && out_free;
		sticky_d  = (func_q == sfpa_pkg::FN_CLR) ? 1'b0 : (sticky_q | ovf_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sfpa_pkg::ST_IDLE: begin
				if (in_valid) begin
					func_q <= in_data.func;
					a_q    <= in_data.a;
					b_q    <= in_data.b;
				end
			end
			sfpa_pkg::ST_EXEC: begin
				case (func_q)
					sfpa_pkg::FN_ADD, sfpa_pkg::FN_SUB,
					sfpa_pkg::FN_INC, sfpa_pkg::FN_DEC: begin
						res_q <= add_res;
						ovf_q <= add_ovf;
					end
					sfpa_pkg::FN_MUL: begin
						prod_q <= {32'd0, ma} * {32'd0, mb};
					end
					sfpa_pkg::FN_DIV: begin
						if (b_zero) begin
							res_q <= (a_q > 32'sd0) ? sfpa_pkg::INT_MAX : sfpa_pkg::INT_MIN;
							ovf_q <= 1'b1;
						end
					end
					sfpa_pkg::FN_ITF: begin
						res_q <= itf_res;
						ovf_q <= itf_ovf;
					end
					sfpa_pkg::FN_FTI: begin
						res_q <= fti_res;
						ovf_q <= 1'b0;
					end
					default: begin
						res_q <= '0;
						ovf_q <= 1'b0;
					end
				endcase
			end
			sfpa_pkg::ST_MUL: begin
				{ovf_q, res_q} <= sat_mag(mul_mag, neg);
			end
			sfpa_pkg::ST_DIV: begin
				if (div_done) {ovf_q, res_q} <= sat_mag(div_mag, neg);
			end
			default: begin
			end
		endcase
	end

	// output register and sticky flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sticky_q    <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			sticky_q    <= sticky_d;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.result          <= res_q;
			out_q.overflow        <= ovf_q;
			out_q.sticky_overflow <= sticky_d;
			out_q.less            <= (a_q < b_q);
			out_q.equal           <= (a_q == b_q);
			out_q.greater         <= (a_q > b_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == sfpa_pkg::ST_DIV))
		else $error("divider finished outside the divide state");

	a_ovf_sets_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_q.overflow || out_q.sticky_overflow))
		else $error("overflow reported without sticky flag");

	a_cmp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot({out_q.less, out_q.equal, out_q.greater}))
		else $error("comparison flags not one-hot");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfpa_pkg::ST_FIN && out_valid_q && out_stall)
		|=> (state_q == sfpa_pkg::ST_FIN && out_valid_q))
		else $error("finished result dropped while output stalled");

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the saturating fixed-point ALU core.
// ----------------------------------------------------------------------------
// Directed operands cover the saturation limits and rounding ties. They also
// cover divide by zero, clearing the sticky flag and the unused opcodes.
// Random traffic follows, with sender gaps and receiver stalls at several
// rates. A long receiver hold-off fills the core and stalls its input.
// Every result is checked against a local model of the ALU.
// ----------------------------------------------------------------------------
module tb;

	localparam int FRAC = sfpa_pkg::FRAC_BITS_DEF;
	localparam logic [3:0] FN_UNUSED_LO = 4'd9;
	localparam logic [3:0] FN_UNUSED_HI = 4'd15;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_TAIL = 60;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 432;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sfpa_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sfpa_pkg::out_t out_data;

	sfpa_pkg::out_t alu_expected[$];
	sfpa_pkg::out_t want;
	bit sticky_model = 1'b0;
	int errors = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;

	saturating_fixed_point_alu_core #(.FRAC_BITS(FRAC)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #1 clk = ~clk;

	function automatic logic signed [31:0] clamp_q(longint v, inout bit ovf);
		if (v > longint'(sfpa_pkg::INT_MAX)) begin
			ovf = 1'b1;
			return sfpa_pkg::INT_MAX;
		end
		if (v < longint'(sfpa_pkg::INT_MIN)) begin
			ovf = 1'b1;
			return sfpa_pkg::INT_MIN;
		end
		return v[31:0];
	endfunction

	// magnitude plus sign back to a saturated 32-bit value
	function automatic logic signed [31:0] sat_magnitude(longint unsigned mag, bit neg,
			inout bit ovf);
		logic signed [31:0] low;
		low = mag[31:0];
		if (neg) begin
			if (mag > 64'h8000_0000) begin
				ovf = 1'b1;
				return sfpa_pkg::INT_MIN;
			end
			return -low;
		end
		if (mag > 64'h7FFF_FFFF) begin
			ovf = 1'b1;
			return sfpa_pkg::INT_MAX;
		end
		return low;
	endfunction

	function automatic sfpa_pkg::out_t alu_predict(sfpa_pkg::in_t op, inout bit sticky);
		longint sa, sb, lv;
		longint unsigned ma, mb, m, q, rem;
		bit neg, ovf;
		logic signed [31:0] r;
		sfpa_pkg::out_t o;
		sa = op.a;
		sb = op.b;
		ma = (sa < 0) ? -sa : sa;
		mb = (sb < 0) ? -sb : sb;
		neg = (sa < 0) != (sb < 0);
		ovf = 1'b0;
		r = '0;
		case (op.func)
			sfpa_pkg::FN_ADD: r = clamp_q(sa + sb, ovf);
			sfpa_pkg::FN_SUB: r = clamp_q(sa - sb, ovf);
			sfpa_pkg::FN_MUL: begin
				m = ma * mb;
				m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
				r = sat_magnitude(m, neg, ovf);
			end
			sfpa_pkg::FN_DIV: begin
				if (sb == 0) begin
					ovf = 1'b1;
					r = (sa > 0) ? sfpa_pkg::INT_MAX : sfpa_pkg::INT_MIN;
				end else begin
					m = ma << FRAC;
					q = m / mb;
					rem = m % mb;
					// round half away from zero
					if (2 * rem >= mb)
						q = q + 1;
					r = sat_magnitude(q, neg, ovf);
				end
			end
			sfpa_pkg::FN_INC: r = clamp_q(sa + 1, ovf);
			sfpa_pkg::FN_DEC: r = clamp_q(sa - 1, ovf);
			sfpa_pkg::FN_ITF: r = clamp_q(sa * (longint'(1) << FRAC), ovf);
			sfpa_pkg::FN_FTI: begin
				m = ma >> FRAC;
				lv = (sa < 0) ? -longint'(m) : longint'(m);
				r = lv[31:0];
			end
			sfpa_pkg::FN_CLR: sticky = 1'b0;
			default: ;
		endcase
		if (ovf)
			sticky = 1'b1;
		o.result = r;
		o.overflow = ovf;
		o.sticky_overflow = sticky;
		o.less = sa < sb;
		o.equal = sa == sb;
		o.greater = sa > sb;
		return o;
	endfunction

	function automatic logic signed [31:0] rand_operand();
		logic signed [31:0] v;
		case ($urandom_range(5))
			0: begin
				case ($urandom_range(6))
					0: v = sfpa_pkg::INT_MAX;
					1: v = sfpa_pkg::INT_MIN;
					2: v = 0;
					3: v = 1;
					4: v = -1;
					5: v = 32'sd1 <<< FRAC;
					default: v = -(32'sd1 <<< FRAC);
				endcase
			end
			1: v = $urandom_range(0, 1023);
			2: v = $urandom_range(0, 1 << 20);
			default: v = $urandom;
		endcase
		if ($urandom_range(1))
			v = -v;
		return v;
	endfunction

	function automatic sfpa_pkg::in_t rand_item();
		sfpa_pkg::in_t op;
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			op.func = 4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
		else if (pick < 14)
			op.func = sfpa_pkg::FN_CLR;
		else
			op.func = 4'($urandom_range(sfpa_pkg::FN_ADD, sfpa_pkg::FN_FTI));
		op.a = rand_operand();
		op.b = ($urandom_range(7) == 0) ? op.a : rand_operand();
		return op;
	endfunction

	// Offer one item, hold it until the transfer, then log its expected result
	task automatic send_item(sfpa_pkg::in_t op);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data <= op;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		alu_expected.push_back(alu_predict(op, sticky_model));
	endtask

	task automatic send_op(logic [3:0] f, logic signed [31:0] a, logic signed [31:0] b);
		sfpa_pkg::in_t op;
		op.func = f;
		op.a = a;
		op.b = b;
		send_item(op);
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		while (alu_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_op(sfpa_pkg::FN_ADD, sfpa_pkg::INT_MAX, 32'sd1);
		send_op(sfpa_pkg::FN_ADD, sfpa_pkg::INT_MIN, -32'sd1);
		send_op(sfpa_pkg::FN_SUB, sfpa_pkg::INT_MIN, 32'sd1);
		send_op(sfpa_pkg::FN_SUB, sfpa_pkg::INT_MAX, -32'sd1);
		// sticky flag still set on an unused code, then cleared
		send_op(FN_UNUSED_HI, 32'sd5, 32'sd5);
		send_op(sfpa_pkg::FN_CLR, 32'sd3, 32'sd4);
		send_op(FN_UNUSED_LO, 32'sd7, -32'sd7);
		send_op(sfpa_pkg::FN_MUL, 32'sh180, 32'sh100);
		send_op(sfpa_pkg::FN_MUL, 32'sd1, 32'sh80);
		send_op(sfpa_pkg::FN_MUL, -32'sd1, 32'sh80);
		send_op(sfpa_pkg::FN_MUL, sfpa_pkg::INT_MAX, sfpa_pkg::INT_MAX);
		send_op(sfpa_pkg::FN_MUL, sfpa_pkg::INT_MIN, 32'sd1 <<< FRAC);
		send_op(sfpa_pkg::FN_DIV, 32'sd100, 32'sd0);
		send_op(sfpa_pkg::FN_DIV, 32'sd0, 32'sd0);
		send_op(sfpa_pkg::FN_DIV, -32'sd100, 32'sd0);
		send_op(sfpa_pkg::FN_DIV, 32'sh100, 32'sh300);
		send_op(sfpa_pkg::FN_DIV, sfpa_pkg::INT_MIN, -32'sd1);
		send_op(sfpa_pkg::FN_DIV, sfpa_pkg::INT_MIN, 32'sd1 <<< FRAC);
		send_op(sfpa_pkg::FN_INC, sfpa_pkg::INT_MAX, 32'sd0);
		send_op(sfpa_pkg::FN_DEC, sfpa_pkg::INT_MIN, 32'sd0);
		send_op(sfpa_pkg::FN_ITF, sfpa_pkg::INT_MAX, -32'sd5);
		send_op(sfpa_pkg::FN_ITF, -32'sd5, sfpa_pkg::INT_MIN);
		send_op(sfpa_pkg::FN_FTI, -32'sh180, 32'sd0);
		send_op(sfpa_pkg::FN_FTI, sfpa_pkg::INT_MIN, sfpa_pkg::INT_MAX);
		send_op(sfpa_pkg::FN_CLR, sfpa_pkg::INT_MIN, sfpa_pkg::INT_MIN);
		pause_until_drained();
	endtask

	// Hold the receiver off while items keep coming, so the core backs up
	task automatic test_back_pressure();
		sender_idle_pct = 0;
		hold_left <= HOLD_OFF_CYCLES;
		repeat (16)
			send_item(rand_item());
		pause_until_drained();
	endtask

	task automatic test_random(int n, int idle_pct, int stall_pct);
		sender_idle_pct = idle_pct;
		recv_stall_pct <= stall_pct;
		repeat (n)
			send_item(rand_item());
		pause_until_drained();
	endtask

	// Receiver: check each result transfer, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (alu_expected.size() == 0) begin
				$display("%0t: result with nothing expected: %h", $time, out_data);
				errors++;
			end else begin
				want = alu_expected.pop_front();
				if (out_data.result !== want.result ||
						out_data.overflow !== want.overflow ||
						out_data.sticky_overflow !== want.sticky_overflow ||
						out_data.less !== want.less ||
						out_data.equal !== want.equal ||
						out_data.greater !== want.greater) begin
					$display("%0t: mismatch exp r=%h ov=%b st=%b lt=%b eq=%b gt=%b",
						$time, want.result, want.overflow, want.sticky_overflow,
						want.less, want.equal, want.greater);
					$display("%0t:          got r=%h ov=%b st=%b lt=%b eq=%b gt=%b",
						$time, out_data.result, out_data.overflow,
						out_data.sticky_overflow, out_data.less, out_data.equal,
						out_data.greater);
					errors++;
				end
			end
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_pressure();
		test_random(ITEMS_PER_PHASE, 0, 0);
		test_random(ITEMS_PER_PHASE, 52, 0);
		test_random(ITEMS_PER_PHASE, 0, 52);
		test_random(ITEMS_PER_PHASE, 24, 24);
		repeat (DRAIN_TAIL)
			@(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
